// File: src/rrbs_pkg.sv
// ----------------------------------------------------------------------------
// rrbs_pkg
// Shared types and codes for the round-robin backend selector: request and
// result words, command and register codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rrbs_pkg;

    localparam logic [2:0] CMD_FIND_ANY      = 3'd0;
    localparam logic [2:0] CMD_FIND_SPECIFIC = 3'd1;
    localparam logic [2:0] CMD_MARK_DEAD     = 3'd2;
    localparam logic [2:0] CMD_MARK_ALIVE    = 3'd3;
    localparam logic [2:0] CMD_FINISH        = 3'd4;
    localparam logic [2:0] CMD_SET_REFUSED   = 3'd5;

    localparam logic [7:0] CFG_INSTANCE_COUNT  = 8'd0;
    localparam logic [7:0] CFG_VALID_MASK      = 8'd1;
    localparam logic [7:0] CFG_RETRY_DELAY     = 8'd2;
    localparam logic [7:0] CFG_SWITCH_TO_KNOWN = 8'd3;

    localparam logic [4:0]  RST_INSTANCE_COUNT = 5'd1;
    localparam logic [15:0] RST_RETRY_DELAY    = 16'd10;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  instance_req;
        logic        has_session_key;
        logic [31:0] now;
        logic [31:0] refuse_until;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  chosen;
        logic [31:0] open_requests;
        logic [31:0] handled_requests;
        logic [31:0] failed_requests;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_NORM,
        ST_SCAN
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic rr_init;
        logic norm_sub;
        logic visit;
        logic advance;
        logic exec;
        logic no_result;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_path;
        logic n_zero;
        logic ptr_ge_n;
        logic hit;
        logic last;
    } sts_t;

endpackage

// File: src/rrbs_ctrl.sv
// ----------------------------------------------------------------------------
// rrbs_ctrl
// Controller for the backend selector: accepts a command word, chooses
// between a single-entry operation and a round-robin scan, and steps the scan.
// ----------------------------------------------------------------------------
module rrbs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rrbs_pkg::sts_t sts,
    output rrbs_pkg::ctl_t ctl,
    output logic          busy
);
    import rrbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.scan_path && !sts.n_zero)
                begin
                    state_next = ST_NORM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_NORM:
            begin
                if (!sts.ptr_ge_n)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.hit || sts.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            ST_DECODE:
            begin
                if (sts.scan_path)
                begin
                    ctl.no_result = sts.n_zero;
                    ctl.rr_init   = !sts.n_zero;
                end
                else
                begin
                    ctl.exec = 1'b1;
                end
            end
            ST_NORM:
            begin
                // wrap the first pointer step by repeated subtraction
                ctl.norm_sub = sts.ptr_ge_n;
            end
            ST_SCAN:
            begin
                ctl.visit     = 1'b1;
                ctl.no_result = !sts.hit && sts.last;
                ctl.advance   = !sts.hit && !sts.last;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

`ifndef SYNTH
    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |->
            ($past(state_reg) == ST_NORM || $past(state_reg) == ST_SCAN))
        else $error("scan entered without pointer wrap");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (state_reg == ST_DECODE))
        else $error("accepted word not decoded");
`endif

endmodule

// File: src/rrbs_datapath.sv
// ----------------------------------------------------------------------------
// rrbs_datapath
// Entry table, configuration registers, round-robin pointer and result
// register; performs one entry access per cycle as the controller commands.
// ----------------------------------------------------------------------------
module rrbs_datapath #(
    parameter int MAX_ENTRIES = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rrbs_pkg::req_t request,
    input  rrbs_pkg::ctl_t ctl,
    output rrbs_pkg::sts_t sts,
    input  logic           cfg_valid,
    input  logic [7:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    output rrbs_pkg::res_t result,
    output logic           done
);
    import rrbs_pkg::*;

    // the 5-bit count never reaches an entry above 31
    localparam int DEPTH = (MAX_ENTRIES < 32) ? MAX_ENTRIES : 32;
    localparam int IW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);

    logic [4:0]  count_reg;
    logic [15:0] mask_reg;
    logic [15:0] retry_reg;
    logic        switch_reg;

    req_t    in_reg;
    logic [PW-1:0] rr_reg;
    logic [PW-1:0] cnt_reg;
    res_t    res_reg;
    logic    done_reg;

    logic [TIME_BITS-1:0] dead_reg    [DEPTH];
    logic                 rf_reg      [DEPTH];
    logic [TIME_BITS-1:0] ru_reg      [DEPTH];
    logic [31:0]          open_reg    [DEPTH];
    logic [31:0]          handled_reg [DEPTH];
    logic [31:0]          fail_reg    [DEPTH];

    logic [PW-1:0]        n_act;
    logic                 known;
    logic [IW-1:0]        ei;
    logic [31:0]          ei_w;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] d;
    logic                 rf;
    logic [TIME_BITS-1:0] ru;
    logic [31:0]          oc;
    logic [31:0]          hc;
    logic [31:0]          fc;
    logic                 ent_valid;
    logic                 acc_ok;
    logic                 acc_clr;
    logic                 alive;
    logic                 revive;
    logic                 hit_visit;
    logic                 spec_ok;
    logic                 rep_exec;
    logic [PW-1:0]        rr_inc;
    logic [PW-1:0]        cnt_inc;

    logic                 dead_we;
    logic [TIME_BITS-1:0] dead_wd;
    logic                 rf_we;
    logic                 rf_wd;
    logic                 ru_we;
    logic                 open_we;
    logic [31:0]          open_wd;
    logic                 handled_we;
    logic                 fail_we;
    res_t                 post;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= RST_INSTANCE_COUNT;
            mask_reg   <= '0;
            retry_reg  <= RST_RETRY_DELAY;
            switch_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INSTANCE_COUNT:  count_reg  <= cfg_data[4:0];
                CFG_VALID_MASK:      mask_reg   <= cfg_data[15:0];
                CFG_RETRY_DELAY:     retry_reg  <= cfg_data[15:0];
                CFG_SWITCH_TO_KNOWN: switch_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            in_reg <= request;
        end
    end

    assign n_act   = (32'(count_reg) > DEPTH) ? PW'(DEPTH) : PW'(count_reg);
    assign known   = 32'(in_reg.instance_req) < 32'(n_act);
    assign now_t   = TIME_BITS'(in_reg.now);
    assign rr_inc  = PW'(rr_reg + PW'(1));
    assign cnt_inc = PW'(cnt_reg + PW'(1));

    assign ei   = ctl.visit ? rr_reg[IW-1:0] : in_reg.instance_req[IW-1:0];
    assign ei_w = 32'(ei);

    assign d  = dead_reg[ei];
    assign rf = rf_reg[ei];
    assign ru = ru_reg[ei];
    assign oc = open_reg[ei];
    assign hc = handled_reg[ei];
    assign fc = fail_reg[ei];

    assign ent_valid = (ei_w < 32'd16) && mask_reg[ei_w[3:0]];
    assign acc_ok    = in_reg.has_session_key || !rf || (now_t > ru);
    assign acc_clr   = !in_reg.has_session_key && rf && (now_t > ru);
    assign revive    = (d != '0) && (d < now_t);
    assign alive     = (d == '0) || revive;
    assign hit_visit = alive && ent_valid && acc_ok;
    assign spec_ok   = known && ent_valid && acc_ok;

    always_comb
    begin
        dead_we    = 1'b0;
        dead_wd    = '0;
        rf_we      = 1'b0;
        rf_wd      = 1'b0;
        ru_we      = 1'b0;
        open_we    = 1'b0;
        open_wd    = oc;
        handled_we = 1'b0;
        fail_we    = 1'b0;
        rep_exec   = 1'b0;
        if (ctl.visit)
        begin
            dead_we = revive;
            rf_we   = alive && ent_valid && acc_clr;
            open_we = hit_visit;
            open_wd = oc + 32'd1;
        end
        else if (ctl.exec)
        begin
            case (in_reg.cmd)
                CMD_FIND_SPECIFIC:
                begin
                    rf_we    = known && ent_valid && acc_clr;
                    open_we  = spec_ok;
                    open_wd  = oc + 32'd1;
                    rep_exec = spec_ok;
                end
                CMD_MARK_DEAD:
                begin
                    open_we  = known;
                    open_wd  = (oc != 32'd0) ? oc - 32'd1 : oc;
                    fail_we  = known;
                    dead_we  = known;
                    dead_wd  = now_t + TIME_BITS'(retry_reg);
                    rep_exec = known;
                end
                CMD_MARK_ALIVE:
                begin
                    dead_we  = known;
                    rep_exec = known;
                end
                CMD_FINISH:
                begin
                    open_we    = known;
                    open_wd    = (oc != 32'd0) ? oc - 32'd1 : oc;
                    handled_we = known;
                    rep_exec   = known;
                end
                CMD_SET_REFUSED:
                begin
                    rf_we    = known;
                    rf_wd    = 1'b1;
                    ru_we    = known;
                    rep_exec = known;
                end
                default:
                begin
                    rep_exec = 1'b0;
                end
            endcase
        end
    end

    // a scan hit always reports found, a single-entry command only for find_specific
    always_comb
    begin
        post.found            = ctl.visit || (in_reg.cmd == CMD_FIND_SPECIFIC);
        post.chosen           = ei_w[3:0];
        post.open_requests    = open_we ? open_wd : oc;
        post.handled_requests = handled_we ? hc + 32'd1 : hc;
        post.failed_requests  = fail_we ? fc + 32'd1 : fc;
    end

    // entry table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                dead_reg[k]    <= '0;
                rf_reg[k]      <= 1'b0;
                ru_reg[k]      <= '0;
                open_reg[k]    <= '0;
                handled_reg[k] <= '0;
                fail_reg[k]    <= '0;
            end
        end
        else
        begin
            if (dead_we)
            begin
                dead_reg[ei] <= dead_wd;
            end
            if (rf_we)
            begin
                rf_reg[ei] <= rf_wd;
            end
            if (ru_we)
            begin
                ru_reg[ei] <= TIME_BITS'(in_reg.refuse_until);
            end
            if (open_we)
            begin
                open_reg[ei] <= open_wd;
            end
            if (handled_we)
            begin
                handled_reg[ei] <= post.handled_requests;
            end
            if (fail_we)
            begin
                fail_reg[ei] <= post.failed_requests;
            end
        end
    end

    // round-robin pointer and visit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rr_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (ctl.rr_init)
        begin
            rr_reg  <= rr_inc;
            cnt_reg <= '0;
        end
        else if (ctl.norm_sub)
        begin
            rr_reg <= rr_reg - n_act;
        end
        else if (ctl.advance)
        begin
            rr_reg  <= (rr_inc == n_act) ? '0 : rr_inc;
            cnt_reg <= cnt_inc;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if ((ctl.visit && hit_visit) || (ctl.exec && rep_exec))
        begin
            res_reg <= post;
        end
        else if (ctl.exec || ctl.no_result)
        begin
            res_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (ctl.visit && hit_visit) || ctl.exec || ctl.no_result;
        end
    end

    assign sts.scan_path = (in_reg.cmd == CMD_FIND_ANY) ||
                           (in_reg.cmd == CMD_FIND_SPECIFIC && !known && switch_reg);
    assign sts.n_zero    = n_act == '0;
    assign sts.ptr_ge_n  = rr_reg >= n_act;
    assign sts.hit       = hit_visit;
    assign sts.last      = cnt_inc >= n_act;

    assign result = res_reg;
    assign done   = done_reg;

`ifndef SYNTH
    a_visit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.visit |-> (rr_reg < n_act))
        else $error("scan pointer outside active entries");
    a_one_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.visit && hit_visit, ctl.exec, ctl.no_result}))
        else $error("conflicting result sources");
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(ctl.visit || ctl.exec || ctl.no_result))
        else $error("result word without cause");
`endif

endmodule

// File: src/round_robin_backend_selector_top.sv
// ----------------------------------------------------------------------------
// round_robin_backend_selector_top
// Round-robin backend selector with health backoff.
// ----------------------------------------------------------------------------
// A command word on request is accepted when start is high and busy is low.
// Exactly one result word follows for each command: it sits on result for
// one cycle with done high, and the receiver takes it then; it cannot stall.
// Single-entry commands (find_specific on a known entry or with the fallback
// off, mark_dead, mark_alive, finish, set_refused, undefined codes) give done
// from the decode state. find_any, and find_specific falling back to
// it, runs through decode, w subtract steps that wrap the first pointer
// advance and a scan of v entries, one per cycle through the single table
// access port; v is 1 to the active entry count (at most 16), and w is 1
// when the advance steps past the last active entry, more only when the
// entry count was lowered since the last scan (at most 16), 0 otherwise.
// With no active entry the result follows decode with no scan.
// A new command is taken in the cycle its predecessor's result is shown.
// The configuration channel (cfg_valid, cfg_ready always high, cfg_index, cfg_data) is
// written by the user only while the block is idle, which the block does not enforce;
// unknown indexes are ignored. Reset clears the table, the pointer and the counters
// and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module round_robin_backend_selector_top #(
    parameter int MAX_ENTRIES = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rrbs_pkg::req_t request,
    output logic           done,
    output rrbs_pkg::res_t result,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import rrbs_pkg::*;

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    rrbs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    rrbs_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .ctl       (ctl),
        .sts       (sts),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .done      (done)
    );

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word while no command was in work");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin backend selector. A short directed
// script covers reset behavior, counter saturation, dead-time wrap, refusal
// expiry and unknown indexes. Several register settings follow, each with
// random commands against an in-bench model of the backend table.
// ----------------------------------------------------------------------------
module tb_top;
    import rrbs_pkg::*;

    localparam logic [2:0] CMD_RSVD_A = 3'd6;
    localparam logic [2:0] CMD_RSVD_B = 3'd7;
    localparam logic [7:0] CFG_UNUSED = 8'hFF;

    localparam int   AT_RESET_ROWS = 6;
    localparam int   N_PHASES      = 14;
    localparam int   PHASE_ITEMS   = 125;
    localparam int   QUIET_LIMIT   = 2000;
    localparam int   TAIL_CYCLES   = 40;
    localparam res_t NO_RESULT     = '0;

    typedef struct {
        req_t word;
        bit   typed;
        res_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        done;
    res_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    // backend table model
    logic [4:0]  cfg_count;
    logic [15:0] cfg_mask;
    logic [15:0] cfg_delay;
    bit          cfg_switch;
    logic [3:0]  rr_ptr;
    logic [31:0] dead_t    [16];
    bit          refused   [16];
    logic [31:0] refused_t [16];
    logic [31:0] open_n    [16];
    logic [31:0] handled_n [16];
    logic [31:0] failed_n  [16];

    res_t        due_results[$];
    row_t        script[$];
    int          faults;
    int          quiet_cycles;
    logic [31:0] clock_s;

    round_robin_backend_selector_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int unsigned live_count();
        return (cfg_count > 5'd16) ? 16 : int'(cfg_count);
    endfunction

    function automatic bit entry_valid(input int unsigned i);
        return (i < 16) && cfg_mask[i];
    endfunction

    // refusal check, drops a refusal whose time has run out
    function automatic bit takes_request(input int unsigned i, input bit session,
                                         input logic [31:0] t_now);
        if (session || !refused[i])
            return 1'b1;
        if (t_now > refused_t[i])
        begin
            refused[i] = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit scan_pool(input bit session, input logic [31:0] t_now,
                                     output logic [3:0] pick);
        int unsigned n;
        int unsigned i;
        n = live_count();
        pick = '0;
        for (int unsigned step = 0; step < n; step++)
        begin
            rr_ptr = 4'((32'(rr_ptr) + 1) % n);
            i = 32'(rr_ptr);
            if (dead_t[i] != 0 && dead_t[i] < t_now)
                dead_t[i] = '0;
            if (dead_t[i] == 0 && entry_valid(i) && takes_request(i, session, t_now))
            begin
                open_n[i]++;
                pick = i[3:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic res_t route_request(input req_t w);
        int unsigned idx;
        bit          known;
        bit          hit;
        bit          report;
        logic [3:0]  pick;
        res_t        r;
        idx    = 32'(w.instance_req);
        known  = idx < live_count();
        hit    = 1'b0;
        report = 1'b0;
        pick   = '0;
        case (w.cmd)
            CMD_FIND_ANY:
            begin
                hit    = scan_pool(w.has_session_key, w.now, pick);
                report = hit;
            end
            CMD_FIND_SPECIFIC:
            begin
                if (!known)
                begin
                    if (cfg_switch)
                    begin
                        hit    = scan_pool(w.has_session_key, w.now, pick);
                        report = hit;
                    end
                end
                else if (entry_valid(idx) && takes_request(idx, w.has_session_key, w.now))
                begin
                    open_n[idx]++;
                    pick   = idx[3:0];
                    hit    = 1'b1;
                    report = 1'b1;
                end
            end
            CMD_MARK_DEAD, CMD_MARK_ALIVE, CMD_FINISH, CMD_SET_REFUSED:
            begin
                if (known)
                begin
                    pick   = idx[3:0];
                    report = 1'b1;
                    case (w.cmd)
                        CMD_MARK_DEAD:
                        begin
                            if (open_n[idx] != 0)
                                open_n[idx]--;
                            failed_n[idx]++;
                            dead_t[idx] = w.now + 32'(cfg_delay);
                        end
                        CMD_MARK_ALIVE:
                            dead_t[idx] = '0;
                        CMD_FINISH:
                        begin
                            if (open_n[idx] != 0)
                                open_n[idx]--;
                            handled_n[idx]++;
                        end
                        default:
                        begin
                            refused[idx]   = 1'b1;
                            refused_t[idx] = w.refuse_until;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        r = NO_RESULT;
        r.found = hit;
        if (report)
        begin
            r.chosen           = pick;
            r.open_requests    = open_n[pick];
            r.handled_requests = handled_n[pick];
            r.failed_requests  = failed_n[pick];
        end
        return r;
    endfunction

    function automatic req_t make_item();
        req_t        w;
        int unsigned roll;
        int unsigned lc;
        lc = live_count();
        w  = '0;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            w.cmd = CMD_FIND_ANY;
        else if (roll < 55)
            w.cmd = CMD_FIND_SPECIFIC;
        else if (roll < 67)
            w.cmd = CMD_MARK_DEAD;
        else if (roll < 77)
            w.cmd = CMD_MARK_ALIVE;
        else if (roll < 90)
            w.cmd = CMD_FINISH;
        else if (roll < 97)
            w.cmd = CMD_SET_REFUSED;
        else
            w.cmd = $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;
        roll = $urandom_range(0, 99);
        if (roll < 70 && lc > 0)
            w.instance_req = 8'($urandom_range(0, lc - 1));
        else if (roll < 85)
            w.instance_req = 8'($urandom_range(0, 15));
        else
            w.instance_req = 8'($urandom_range(0, 255));
        w.has_session_key = ($urandom_range(0, 3) == 0);
        clock_s = clock_s + 32'($urandom_range(0, 3));
        w.now = ($urandom_range(0, 15) == 0) ? 32'($urandom) : clock_s;
        w.refuse_until = ($urandom_range(0, 7) == 0) ? 32'($urandom)
                                                      : w.now + 32'($urandom_range(0, 12));
        return w;
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [7:0] idx, input bit ses,
                           input logic [31:0] t_now, input logic [31:0] t_refuse,
                           input bit typed, input res_t want);
        row_t r;
        r.word.cmd             = cmd;
        r.word.instance_req    = idx;
        r.word.has_session_key = ses;
        r.word.now             = t_now;
        r.word.refuse_until    = t_refuse;
        r.typed                = typed;
        r.want                 = want;
        script.push_back(r);
    endtask

    task automatic issue(input req_t w, input bit typed, input res_t want);
        res_t modeled;
        @(negedge clk);
        start   <= 1'b1;
        request <= w;
        do
            @(posedge clk);
        while (busy);
        modeled = route_request(w);
        due_results.push_back(typed ? want : modeled);
    endtask

    task automatic hold_off(input int n);
        repeat (n) @(negedge clk) start <= 1'b0;
    endtask

    // lower start and let every owed result come back
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [31:0] value,
                             input logic [31:0] keep);
        logic [31:0] data;
        data = (value & keep) | (32'($urandom) & ~keep);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_INSTANCE_COUNT:  cfg_count  = data[4:0];
            CFG_VALID_MASK:      cfg_mask   = data[15:0];
            CFG_RETRY_DELAY:     cfg_delay  = data[15:0];
            CFG_SWITCH_TO_KNOWN: cfg_switch = data[0];
            default: ;
        endcase
    endtask

    task automatic set_registers(input logic [4:0] count, input logic [15:0] mask,
                                 input logic [15:0] delay, input bit sw);
        cfg_write(CFG_INSTANCE_COUNT, 32'(count), 32'h1F);
        cfg_write(CFG_VALID_MASK, 32'(mask), 32'hFFFF);
        cfg_write(CFG_RETRY_DELAY, 32'(delay), 32'hFFFF);
        cfg_write(CFG_SWITCH_TO_KNOWN, 32'(sw), 32'h1);
        // unmapped index must leave everything alone
        cfg_write(CFG_UNUSED, 32'($urandom), 32'h0);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        faults++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    // result checker
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                faults++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, result);
            end
            else
            begin
                want = due_results.pop_front();
                if (result.found !== want.found)
                    note_mismatch("found", 32'(want.found), 32'(result.found));
                if (result.chosen !== want.chosen)
                    note_mismatch("chosen", 32'(want.chosen), 32'(result.chosen));
                if (result.open_requests !== want.open_requests)
                    note_mismatch("open_requests", want.open_requests, result.open_requests);
                if (result.handled_requests !== want.handled_requests)
                    note_mismatch("handled_requests", want.handled_requests,
                                  result.handled_requests);
                if (result.failed_requests !== want.failed_requests)
                    note_mismatch("failed_requests", want.failed_requests,
                                  result.failed_requests);
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        bit          idle_on;
        logic [4:0]  p_count;
        logic [15:0] p_mask;
        logic [15:0] p_delay;
        bit          p_sw;

        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        faults    = 0;
        clock_s   = '0;

        cfg_count  = RST_INSTANCE_COUNT;
        cfg_mask   = '0;
        cfg_delay  = RST_RETRY_DELAY;
        cfg_switch = 1'b0;
        rr_ptr     = '0;
        for (int i = 0; i < 16; i++)
        begin
            dead_t[i]    = '0;
            refused[i]   = 1'b0;
            refused_t[i] = '0;
            open_n[i]    = '0;
            handled_n[i] = '0;
            failed_n[i]  = '0;
        end

        // register defaults: one entry, none valid
        add_row(CMD_FIND_ANY, 8'd0, 1'b0, 32'd0, 32'd0, 1'b1, NO_RESULT);
        add_row(CMD_FIND_SPECIFIC, 8'd0, 1'b0, 32'd0, 32'd0, 1'b1, NO_RESULT);
        add_row(CMD_RSVD_A, 8'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_RESULT);
        add_row(CMD_RSVD_B, 8'd255, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_RESULT);
        add_row(CMD_MARK_DEAD, 8'd200, 1'b0, 32'd3, 32'd0, 1'b1, NO_RESULT);
        add_row(CMD_FINISH, 8'd0, 1'b0, 32'd0, 32'd0, 1'b1,
                res_t'{1'b0, 4'd0, 32'd0, 32'd1, 32'd0});
        // all sixteen valid, longest retry delay, fallback on
        add_row(CMD_FIND_ANY, 8'd0, 1'b0, 32'd0, 32'd0, 1'b1,
                res_t'{1'b1, 4'd1, 32'd1, 32'd0, 32'd0});
        add_row(CMD_FINISH, 8'd1, 1'b0, 32'd0, 32'd0, 1'b1,
                res_t'{1'b0, 4'd1, 32'd0, 32'd1, 32'd0});
        // open count stays at zero
        add_row(CMD_FINISH, 8'd1, 1'b0, 32'd0, 32'd0, 1'b1,
                res_t'{1'b0, 4'd1, 32'd0, 32'd2, 32'd0});
        add_row(CMD_MARK_DEAD, 8'd2, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1,
                res_t'{1'b0, 4'd2, 32'd0, 32'd0, 32'd1});
        // dead time wraps to exactly zero, so the entry stays alive
        add_row(CMD_MARK_DEAD, 8'd3, 1'b0, 32'hFFFF_0001, 32'd0, 1'b1,
                res_t'{1'b0, 4'd3, 32'd0, 32'd0, 32'd1});
        add_row(CMD_FIND_ANY, 8'd0, 1'b0, 32'd5, 32'd0, 1'b0, NO_RESULT);
        add_row(CMD_FIND_SPECIFIC, 8'd255, 1'b0, 32'd5, 32'd0, 1'b0, NO_RESULT);
        add_row(CMD_SET_REFUSED, 8'd4, 1'b0, 32'd6, 32'hFFFF_FFFF, 1'b0, NO_RESULT);
        add_row(CMD_FIND_SPECIFIC, 8'd4, 1'b0, 32'd7, 32'd0, 1'b1, NO_RESULT);
        add_row(CMD_FIND_SPECIFIC, 8'd4, 1'b1, 32'd7, 32'd0, 1'b0, NO_RESULT);
        add_row(CMD_SET_REFUSED, 8'd5, 1'b0, 32'd8, 32'd100, 1'b0, NO_RESULT);
        // refusal holds while now equals its end time, clears once now passes it
        add_row(CMD_FIND_SPECIFIC, 8'd5, 1'b0, 32'd100, 32'd0, 1'b1, NO_RESULT);
        add_row(CMD_FIND_SPECIFIC, 8'd5, 1'b0, 32'd101, 32'd0, 1'b1,
                res_t'{1'b1, 4'd5, 32'd1, 32'd0, 32'd0});
        add_row(CMD_MARK_ALIVE, 8'd2, 1'b0, 32'd101, 32'd0, 1'b1,
                res_t'{1'b0, 4'd2, 32'd0, 32'd0, 32'd1});
        add_row(CMD_FIND_ANY, 8'd0, 1'b0, 32'h0001_0000, 32'd0, 1'b0, NO_RESULT);
        add_row(CMD_SET_REFUSED, 8'd15, 1'b0, 32'd0, 32'd0, 1'b0, NO_RESULT);
        add_row(CMD_FIND_SPECIFIC, 8'd15, 1'b0, 32'd0, 32'd0, 1'b1, NO_RESULT);
        add_row(CMD_FIND_SPECIFIC, 8'd16, 1'b1, 32'h8000_0000, 32'd0, 1'b0, NO_RESULT);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < script.size(); k++)
        begin
            if (k == AT_RESET_ROWS)
            begin
                settle();
                set_registers(5'd16, 16'hFFFF, 16'hFFFF, 1'b1);
            end
            issue(script[k].word, script[k].typed, script[k].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: begin p_count = 5'd0;  p_mask = 16'hFFFF; p_delay = 16'd0;    p_sw = 1'b1; end
                1: begin p_count = 5'd31; p_mask = 16'hFFFF; p_delay = 16'hFFFF; p_sw = 1'b0; end
                2: begin p_count = 5'd1;  p_mask = 16'h0001; p_delay = 16'd0;    p_sw = 1'b1; end
                3: begin p_count = 5'd16; p_mask = 16'h0000; p_delay = 16'd5;    p_sw = 1'b1; end
                default:
                begin
                    p_count = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                          : 5'($urandom_range(2, 16));
                    p_mask  = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                          : 16'($urandom | $urandom);
                    p_delay = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 20));
                    p_sw    = 1'($urandom_range(0, 1));
                end
            endcase
            settle();
            set_registers(p_count, p_mask, p_delay, p_sw);
            // some phases run across the 32-bit time wrap
            clock_s = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + 32'($urandom_range(0, 200))
                                                 : 32'($urandom);
            idle_on = (p < N_PHASES - 2) && (p % 4 != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (idle_on && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 19));
                issue(make_item(), 1'b0, NO_RESULT);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (faults == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
